>>> sv/rcpc_pkg.sv
// rcpc_pkg: shared types and constants for the rtcp compound packet checker
// no dependencies; imported by rcpc_member_check and the top level
`default_nettype none

package rcpc_pkg;

  // field widths
  localparam int unsigned CNT_W   = 19;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned CODE_W  = 4;

  // saturation point of the member byte counter
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // reset value of the size limit register
  localparam logic [TOTAL_W-1:0] MAX_BYTES_RESET = 16'd1200;
  localparam logic [TOTAL_W-1:0] MIN_BYTES       = 16'd4;

  // rtcp packet types and header bits
  localparam logic [7:0] TYPE_SR   = 8'd200;
  localparam logic [7:0] TYPE_RR   = 8'd201;
  localparam logic [7:0] TYPE_SDES = 8'd202;
  localparam logic [1:0] RTP_VER   = 2'd2;
  localparam int unsigned PAD_POS  = 5;

  // status codes
  localparam logic [CODE_W-1:0] ST_OK        = 4'd0;
  localparam logic [CODE_W-1:0] ST_SIZE      = 4'd1;
  localparam logic [CODE_W-1:0] ST_VERSION   = 4'd2;
  localparam logic [CODE_W-1:0] ST_LENGTH    = 4'd3;
  localparam logic [CODE_W-1:0] ST_FIRST     = 4'd4;
  localparam logic [CODE_W-1:0] ST_PADDING   = 4'd5;
  localparam logic [CODE_W-1:0] ST_TOO_BIG   = 4'd6;
  localparam logic [CODE_W-1:0] ST_NO_SDES   = 4'd7;
  localparam logic [CODE_W-1:0] ST_MAX_SMALL = 4'd8;

  // input word: one byte of the compound
  typedef struct packed {
    logic [7:0] data_byte;
    logic       member_end;
    logic       compound_end;
  } pkt_word_t;

  // result word
  typedef struct packed {
    logic [CODE_W-1:0]  status;
    logic [TOTAL_W-1:0] total_bytes;
  } res_word_t;

  // header fields of the current member
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  member_type;
    logic [15:0] declared_words;
  } member_hdr_t;

  // what the member check needs
  typedef struct packed {
    member_hdr_t        hdr;
    logic [CNT_W-1:0]   size;
    logic               at_first;
    logic               last;
    logic [TOTAL_W-1:0] running_total;
    logic [TOTAL_W-1:0] max_bytes;
  } check_req_t;

  // what the member check returns
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               sdes_hit;
    logic [TOTAL_W-1:0] total;
  } check_res_t;

endpackage

`default_nettype wire

>>> sv/rtcp_compound_packet_checker_unit.sv
// rtcp_compound_packet_checker_unit: byte-wise rtcp compound packet checker
// the result word is registered in the result register when the compound-end byte leaves the input register
// throughput: one byte per cycle; a compound-end byte waits only while the previous result is held
// the byte counter, header capture and size check settle in one pass per byte
// reset (rst, synchronous): clears all check state, limit returns to 1200 bytes
// depends on rcpc_pkg and rcpc_member_check
`default_nettype none

module rtcp_compound_packet_checker_unit
  import rcpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pkt_valid,
  output logic               pkt_stall,
  input  pkt_word_t          pkt,
  output logic               res_valid,
  input  logic               res_stall,
  output res_word_t          res,
  input  logic               cfg_write,
  input  logic [TOTAL_W-1:0] cfg_data
);

  // input register
  logic              in_valid;
  pkt_word_t         in_word;
  logic              advance;

  // config
  logic [TOTAL_W-1:0] max_bytes;

  // check state
  logic [CODE_W-1:0]  error_latch, error_latch_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [TOTAL_W-1:0] running_total, running_total_next;
  member_hdr_t        hdr, hdr_next;
  logic               at_first, at_first_next;
  logic               saw_sdes, saw_sdes_next;

  logic               mend;
  logic [CNT_W-1:0]   count_inc;
  check_req_t         chk_req;
  check_res_t         chk_res;
  logic [CODE_W-1:0]  status_next;

  // handshake: a byte moves on unless it ends a compound and the result slot is held
  assign advance   = in_valid && (!in_word.compound_end || !res_valid || !res_stall);
  assign pkt_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (pkt_valid && !pkt_stall) || pkt_stall;
    end
    if (pkt_valid && !pkt_stall) begin
      in_word <= pkt;
    end
  end

  // size limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_write) begin
      max_bytes <= cfg_data;
    end
  end

  // header capture and byte count
  always_comb begin
    mend      = in_word.member_end || in_word.compound_end;
    count_inc = (byte_count == CNT_MAX) ? byte_count : byte_count + 1'b1;
    hdr_next  = hdr;
    if (byte_count == 19'd0) begin
      hdr_next.first_byte = in_word.data_byte;
    end
    if (byte_count == 19'd1) begin
      hdr_next.member_type = in_word.data_byte;
    end
    if (byte_count == 19'd2) begin
      hdr_next.declared_words[15:8] = in_word.data_byte;
    end
    if (byte_count == 19'd3) begin
      hdr_next.declared_words[7:0] = in_word.data_byte;
    end
  end

  // member check
  always_comb begin
    chk_req.hdr           = hdr_next;
    chk_req.size          = count_inc;
    chk_req.at_first      = at_first;
    chk_req.last          = in_word.compound_end;
    chk_req.running_total = running_total;
    chk_req.max_bytes     = max_bytes;
  end

  rcpc_member_check u_check (
    .req (chk_req),
    .res (chk_res)
  );

  // byte count update, and state update at member end
  always_comb begin
    error_latch_next   = error_latch;
    running_total_next = running_total;
    saw_sdes_next      = saw_sdes;
    at_first_next      = at_first;
    byte_count_next    = count_inc;
    if (mend) begin
      if (error_latch == ST_OK) begin
        error_latch_next   = chk_res.code;
        running_total_next = chk_res.total;
        saw_sdes_next      = saw_sdes || chk_res.sdes_hit;
      end
      at_first_next   = 1'b0;
      byte_count_next = '0;
    end
    // final status
    status_next = error_latch_next;
    if (status_next == ST_OK && !saw_sdes_next) begin
      status_next = ST_NO_SDES;
    end
    if (max_bytes < MIN_BYTES) begin
      status_next = ST_MAX_SMALL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_word.compound_end)) begin
      error_latch   <= ST_OK;
      byte_count    <= '0;
      running_total <= '0;
      hdr           <= '0;
      at_first      <= 1'b1;
      saw_sdes      <= 1'b0;
    end else if (advance) begin
      error_latch   <= error_latch_next;
      byte_count    <= byte_count_next;
      running_total <= running_total_next;
      hdr           <= hdr_next;
      at_first      <= at_first_next;
      saw_sdes      <= saw_sdes_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_word.compound_end) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (advance && in_word.compound_end) begin
      res.status      <= status_next;
      res.total_bytes <= running_total_next;
    end
  end

  // a stalled byte is always a held one
  assert property (@(posedge clk) disable iff (rst) pkt_stall |-> in_valid)
    else $error("stall raised with an empty input register");

  // compound end leaves a clean state
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_word.compound_end) |=>
      (byte_count == '0) && (error_latch == ST_OK) && at_first && !saw_sdes)
    else $error("state not cleared after compound end");

  // a latched error holds until the compound ends
  assert property (@(posedge clk) disable iff (rst)
    (error_latch != ST_OK) && !(advance && in_word.compound_end) |=>
      (error_latch == $past(error_latch)))
    else $error("latched error changed inside a compound");

  // status codes stay within the defined range
  assert property (@(posedge clk) disable iff (rst) res_valid |-> (res.status <= ST_MAX_SMALL))
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> sv/rcpc_member_check.sv
// rcpc_member_check: validation of one finished rtcp member against its header
// depends on rcpc_pkg
`default_nettype none

module rcpc_member_check
  import rcpc_pkg::*;
(
  input  check_req_t req,
  output check_res_t res
);

  logic              bad_size;
  logic              bad_version;
  logic              bad_length;
  logic              bad_first;
  logic              bad_padding;
  logic              too_big;
  logic [16:0]       words_plus_one;
  logic [CNT_W:0]    sum;

  // individual checks
  always_comb begin
    words_plus_one = {1'b0, req.hdr.declared_words} + 17'd1;
    sum            = {1'b0, req.size} + {{(CNT_W+1-TOTAL_W){1'b0}}, req.running_total};
    bad_size    = (req.size < {{(CNT_W-TOTAL_W){1'b0}}, MIN_BYTES}) || (req.size[1:0] != 2'b00);
    bad_version = (req.hdr.first_byte[7:6] != RTP_VER);
    // size is a multiple of four here, so compare in words
    bad_length  = (req.size[CNT_W-1:2] != words_plus_one);
    bad_first   = req.at_first && (req.hdr.member_type != TYPE_SR)
                  && (req.hdr.member_type != TYPE_RR);
    bad_padding = req.hdr.first_byte[PAD_POS] && !req.last;
    too_big     = (sum > {{(CNT_W+1-TOTAL_W){1'b0}}, req.max_bytes});
  end

  // first failing check wins
  always_comb begin
    res.sdes_hit = 1'b0;
    res.total    = req.running_total;
    priority if (bad_size) begin
      res.code = ST_SIZE;
    end else if (bad_version) begin
      res.code = ST_VERSION;
    end else if (bad_length) begin
      res.code = ST_LENGTH;
    end else if (bad_first) begin
      res.code = ST_FIRST;
    end else if (bad_padding) begin
      res.code = ST_PADDING;
    end else begin
      res.sdes_hit = (req.hdr.member_type == TYPE_SDES);
      if (too_big) begin
        res.code = ST_TOO_BIG;
      end else begin
        res.code  = ST_OK;
        res.total = sum[TOTAL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_rtcp_compound_packet_checker_unit.sv
// tb_rtcp_compound_packet_checker_unit: self-checking bench for the rtcp compound checker
// feeds hand-built and random compounds byte by byte and predicts every status word
// depends on rcpc_pkg and rtcp_compound_packet_checker_unit
module tb_rtcp_compound_packet_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rcpc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_WORDS = 180;

  // predicted status words, built from the accepted byte words
  class compound_status_model;
    logic [TOTAL_W-1:0] limit;
    logic [CODE_W-1:0]  first_err;
    logic [CNT_W-1:0]   byte_pos;
    logic [TOTAL_W:0]   sum_ok;
    logic [7:0]         hdr0;
    logic [7:0]         hdr_type;
    logic [15:0]        hdr_words;
    bit                 first_member;
    bit                 sdes_seen;
    res_word_t          status_q[$];
    int                 mismatches;

    function new();
      limit = MAX_BYTES_RESET;
      mismatches = 0;
      restart();
    endfunction

    // state after a compound ends; the limit stays
    function void restart();
      first_err = ST_OK;
      byte_pos = '0;
      sum_ok = '0;
      hdr0 = '0;
      hdr_type = '0;
      hdr_words = '0;
      first_member = 1'b1;
      sdes_seen = 1'b0;
    endfunction

    // verdict for one finished member, advances the accepted total when clean
    function logic [CODE_W-1:0] member_verdict(int unsigned size, bit last);
      if (size < MIN_BYTES || size % 4 != 0) return ST_SIZE;
      if (hdr0[7:6] != RTP_VER) return ST_VERSION;
      if ((int'(hdr_words) + 1) * 4 != size) return ST_LENGTH;
      if (first_member && hdr_type != TYPE_SR && hdr_type != TYPE_RR) return ST_FIRST;
      if (hdr0[PAD_POS] && !last) return ST_PADDING;
      if (hdr_type == TYPE_SDES) sdes_seen = 1'b1;
      if (sum_ok > limit || size > limit - sum_ok) return ST_TOO_BIG;
      sum_ok = sum_ok + size;
      return ST_OK;
    endfunction

    // one accepted byte word
    function void take_word(pkt_word_t w);
      bit                cend;
      bit                mend;
      logic [CODE_W-1:0] st;
      res_word_t         r;
      cend = w.compound_end;
      mend = w.member_end | cend;
      // header capture by byte position
      case (byte_pos)
        19'd0: hdr0 = w.data_byte;
        19'd1: hdr_type = w.data_byte;
        19'd2: hdr_words[15:8] = w.data_byte;
        19'd3: hdr_words[7:0] = w.data_byte;
        default: ;
      endcase
      if (byte_pos != CNT_MAX) byte_pos = byte_pos + 1'b1;
      // member checks, first error sticks
      if (mend) begin
        if (first_err == ST_OK) first_err = member_verdict(byte_pos, cend);
        first_member = 1'b0;
        byte_pos = '0;
      end
      // compound end gives one status word
      if (cend) begin
        st = first_err;
        if (st == ST_OK && !sdes_seen) st = ST_NO_SDES;
        if (limit < MIN_BYTES) st = ST_MAX_SMALL;
        r.status = st;
        r.total_bytes = (sum_ok > 17'hFFFF) ? 16'hFFFF : sum_ok[TOTAL_W-1:0];
        status_q.push_back(r);
        restart();
      end
    endfunction

    // one accepted status word against the oldest prediction
    function void match_result(res_word_t got);
      res_word_t want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: status word with none expected: status %0d total %0d",
                   $time, got.status, got.total_bytes);
        return;
      end
      want = status_q.pop_front();
      if (got.status !== want.status || got.total_bytes !== want.total_bytes) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"%0t: status word mismatch: expected status %0d total %0d,",
                    " got status %0d total %0d"},
                   $time, want.status, want.total_bytes, got.status, got.total_bytes);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pkt_valid = 1'b0;
  logic               pkt_stall;
  pkt_word_t          pkt = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_word_t          res;
  logic               cfg_write = 1'b0;
  logic [TOTAL_W-1:0] cfg_data = '0;

  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  bit        hold_go = 1'b0;
  bit        hold_seen = 1'b0;
  int        quiet_cycles = 0;
  int        words_sent = 0;
  pkt_word_t tx_q[$];

  compound_status_model status_pred = new();

  always #5 clk = ~clk;

  rtcp_compound_packet_checker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // result side: check each taken word, then pick the next stall
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) status_pred.match_result(res);
    hold_seen <= hold_go;
    if (hold_go && !hold_seen) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (pkt_valid && !pkt_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_rtcp_compound_packet_checker_unit: done, errors");
      $finish;
    end
  end

  // offer one byte word, with random idle cycles ahead of it
  task automatic send_word(input pkt_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt <= w;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    status_pred.take_word(w);
    words_sent++;
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_word(tx_q.pop_front());
  endtask

  // drop valid and wait until every predicted word is out
  task automatic settle();
    pkt_valid <= 1'b0;
    while (status_pred.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [TOTAL_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    status_pred.limit = v;
  endtask

  // queue one member: header, then random payload
  function automatic void add_member(input logic [7:0] b0, input logic [7:0] mtype,
                                     input logic [15:0] words, input int unsigned nbytes,
                                     input bit cend, input bit mark_end);
    pkt_word_t w;
    for (int unsigned i = 0; i < nbytes; i++) begin
      case (i)
        0: w.data_byte = b0;
        1: w.data_byte = mtype;
        2: w.data_byte = words[15:8];
        3: w.data_byte = words[7:0];
        default: w.data_byte = 8'($urandom);
      endcase
      w.member_end   = (i == nbytes - 1) && mark_end;
      w.compound_end = (i == nbytes - 1) && cend;
      tx_q.push_back(w);
    end
  endfunction

  // mostly well-formed compound with occasional broken fields
  function automatic void add_rand_compound();
    int unsigned n;
    int unsigned sdes_at;
    int unsigned words;
    int unsigned nbytes;
    logic [7:0]  b0;
    logic [7:0]  mtype;
    bit          last;
    n = $urandom_range(1, 4);
    sdes_at = (n > 1 && $urandom_range(9) != 0) ? $urandom_range(1, n - 1) : n;
    for (int unsigned i = 0; i < n; i++) begin
      last = (i == n - 1);
      if (i == 0) mtype = $urandom_range(1) ? TYPE_SR : TYPE_RR;
      else if (i == sdes_at) mtype = TYPE_SDES;
      else mtype = 8'($urandom_range(TYPE_SR, TYPE_SDES + 8'd2));
      if ($urandom_range(29) == 0) mtype = 8'($urandom);
      words = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(3);
      nbytes = (words + 1) * 4;
      if ($urandom_range(24) == 0) nbytes = $urandom_range(1, nbytes + 3);
      if ($urandom_range(24) == 0) words = $urandom_range(16'hFFFF);
      b0 = {RTP_VER, 1'b0, 5'($urandom)};
      if ($urandom_range(24) == 0) b0[7:6] = 2'($urandom);
      if (last ? ($urandom_range(3) == 0) : ($urandom_range(29) == 0)) b0[PAD_POS] = 1'b1;
      add_member(b0, mtype, 16'(words), nbytes, last, !last || $urandom_range(5) != 0);
    end
  endfunction

  // random phase: set limit and idling, then compounds until enough words and at least six compounds went in
  task automatic run_phase(input int idle_send, input int idle_recv,
                           input logic [TOTAL_W-1:0] lim);
    int          start_words;
    int          compounds;
    int unsigned n;
    pkt_word_t   w;
    write_limit(lim);
    send_idle_pct = idle_send;
    recv_stall_pct = idle_recv;
    start_words = words_sent;
    compounds = 0;
    while (words_sent - start_words < PHASE_WORDS || compounds < 6) begin
      if ($urandom_range(6) == 0) begin
        // noise: random bytes and random member ends
        n = $urandom_range(1, 10);
        for (int unsigned i = 0; i < n; i++) begin
          w.data_byte = 8'($urandom);
          w.member_end = ($urandom_range(3) == 0);
          w.compound_end = (i == n - 1);
          tx_q.push_back(w);
        end
      end else begin
        add_rand_compound();
      end
      flush_tx();
      compounds++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // clean compounds, one with padding on its last member
    add_member(8'h80, TYPE_RR, 16'd1, 8, 1'b0, 1'b1);
    add_member(8'h81, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    add_member(8'h80, TYPE_SR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'hA0, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    // size, version, length, first type, padding, missing sdes
    add_member(8'h80, TYPE_RR, 16'd1, 6, 1'b1, 1'b1);
    add_member(8'h40, TYPE_RR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    add_member(8'hBF, TYPE_RR, 16'hFFFF, 4, 1'b1, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    add_member(8'hA0, TYPE_RR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    add_member(8'h80, TYPE_RR, 16'd0, 4, 1'b1, 1'b1);
    // compound end without member end
    add_member(8'h80, TYPE_RR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b0);
    // short compounds: header never complete
    add_member(8'hFF, 8'hFF, 16'hFFFF, 2, 1'b1, 1'b1);
    add_member(8'h00, 8'h00, 16'h0000, 1, 1'b1, 1'b1);
    flush_tx();

    // total over the limit
    write_limit(16'd16);
    add_member(8'h80, TYPE_RR, 16'd1, 8, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd2, 12, 1'b1, 1'b1);
    flush_tx();

    // limit lowered between members of one compound
    write_limit(16'd1200);
    add_member(8'h80, TYPE_RR, 16'd1, 8, 1'b0, 1'b1);
    flush_tx();
    write_limit(16'd8);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    flush_tx();

    // limit below one header, then exactly one header
    write_limit(16'd0);
    add_member(8'h80, TYPE_RR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    flush_tx();
    write_limit(16'd3);
    add_member(8'h80, TYPE_SR, 16'd0, 4, 1'b1, 1'b1);
    flush_tx();
    write_limit(16'd4);
    add_member(8'h80, TYPE_RR, 16'd0, 4, 1'b0, 1'b1);
    add_member(8'h80, TYPE_SDES, 16'd0, 4, 1'b1, 1'b1);
    add_member(8'h80, TYPE_RR, 16'd0, 4, 1'b1, 1'b1);
    flush_tx();

    // random phases over idling mixes and limits
    run_phase(0, 0, 16'd1200);
    run_phase(49, 0, 16'hFFFF);
    run_phase(0, 49, 16'd48);
    run_phase(10, 10, 16'd300);

    // long receiver hold while bytes keep coming, so the input side backs up
    write_limit(MAX_BYTES_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    for (int k = 0; k < 6; k++) add_rand_compound();
    flush_tx();

    settle();
    if (status_pred.mismatches == 0) begin
      $display("tb_rtcp_compound_packet_checker_unit: done, clean");
    end else begin
      $display("tb_rtcp_compound_packet_checker_unit: done, errors");
    end
    $finish;
  end

endmodule
